// File: hdl/assert_macros.svh
// Assertion helpers shared by the files that check themselves.
// Every check samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every clock edge.
`define TPW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tpw_pkg.sv
package tpw_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int LEN_W = 31;
	localparam int COORD_W = 32;
	// A displacement needs one bit more than a coordinate.
	localparam int VEC_W = COORD_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_XY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_XZ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_YZ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MASK = 3'd6;

	localparam logic [2:0] MASK_ALL_PERIODIC = 3'b111;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_NON_PERIODIC = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0] lx;
		logic [LEN_W-1:0] ly;
		logic [LEN_W-1:0] lz;
		logic signed [COORD_W-1:0] xy;
		logic signed [COORD_W-1:0] xz;
		logic signed [COORD_W-1:0] yz;
		logic [2:0] mask;
	} cfg_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] rx;
		logic signed [VEC_W-1:0] ry;
		logic signed [VEC_W-1:0] rz;
		logic err;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] wx;
		logic signed [COORD_W-1:0] wy;
		logic signed [COORD_W-1:0] wz;
		logic status;
	} res_t;

endpackage

// File: hdl/tpw_fifo.sv
module tpw_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic wr_fire, rd_fire;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_fire) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_fire) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr_fire) - CW'(rd_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wp_q] <= wr_data;
		end
	end

endmodule

// File: hdl/tpw_front.sv
module tpw_front #(
	parameter int DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               command,
	input  logic signed [tpw_pkg::COORD_W-1:0] first_x,
	input  logic signed [tpw_pkg::COORD_W-1:0] first_y,
	input  logic signed [tpw_pkg::COORD_W-1:0] first_z,
	input  logic signed [tpw_pkg::COORD_W-1:0] second_x,
	input  logic signed [tpw_pkg::COORD_W-1:0] second_y,
	input  logic signed [tpw_pkg::COORD_W-1:0] second_z,
	input  tpw_pkg::cfg_t                      cfg,
	output tpw_pkg::item_t                     head,
	output logic                               head_empty,
	input  logic                               head_pop
);

	localparam int IW = $bits(tpw_pkg::item_t);

	tpw_pkg::item_t it;
	logic [IW-1:0] rd_word;

	// Form the vector to wrap and flag a cell that cannot be wrapped.
	always_comb begin
		it.rx = tpw_pkg::VEC_W'(first_x);
		it.ry = tpw_pkg::VEC_W'(first_y);
		it.rz = tpw_pkg::VEC_W'(first_z);
		if (command) begin
			it.rx = tpw_pkg::VEC_W'(first_x) - tpw_pkg::VEC_W'(second_x);
			it.ry = tpw_pkg::VEC_W'(first_y) - tpw_pkg::VEC_W'(second_y);
			it.rz = tpw_pkg::VEC_W'(first_z) - tpw_pkg::VEC_W'(second_z);
		end
		it.err = (cfg.mask != tpw_pkg::MASK_ALL_PERIODIC) || (cfg.lx == '0) ||
			(cfg.ly == '0) || (cfg.lz == '0);
	end

	tpw_fifo #(
		.W(IW),
		.DEPTH(DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(it),
		.full(full),
		.rd_en(head_pop),
		.rd_data(rd_word),
		.empty(head_empty)
	);

	assign head = tpw_pkg::item_t'(rd_word);

endmodule

// File: hdl/tpw_floordiv.sv
module tpw_floordiv #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 31,
	parameter int PAD = 0,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]         den,
	input  logic [SIDE_W-1:0]        side_in,
	output logic signed [NUM_W:0]    quo,
	output logic [SIDE_W-1:0]        side_out
);

	// Stage 0 takes the magnitude, stages 1..NUM_W each resolve one quotient bit.
	logic [DEN_W-1:0] rem_q [NUM_W+1];
	logic [NUM_W-1:0] mq_q [NUM_W+1];
	logic neg_q [NUM_W+1];
	logic [SIDE_W-1:0] side_q [NUM_W+1];
	logic [DEN_W-1:0] rem_n [NUM_W];
	logic [NUM_W-1:0] mq_n [NUM_W];
	logic signed [NUM_W:0] cq_q [PAD+1];
	logic [SIDE_W-1:0] cs_q [PAD+1];
	logic signed [NUM_W:0] qpos, qfin;

	always_comb begin
		logic [DEN_W:0] t, diff;
		for (int i = 0; i < NUM_W; i++) begin
			t = {rem_q[i], mq_q[i][NUM_W-1]};
			diff = t - {1'b0, den};
			if (t >= {1'b0, den}) begin
				rem_n[i] = diff[DEN_W-1:0];
				mq_n[i] = {mq_q[i][NUM_W-2:0], 1'b1};
			end else begin
				rem_n[i] = t[DEN_W-1:0];
				mq_n[i] = {mq_q[i][NUM_W-2:0], 1'b0};
			end
		end
	end

	// A negative numerator rounds toward minus infinity when a remainder is left.
	assign qpos = $signed({1'b0, mq_q[NUM_W]});
	assign qfin = neg_q[NUM_W] ?
		(-qpos - $signed({{NUM_W{1'b0}}, (rem_q[NUM_W] != '0)})) : qpos;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= '0;
			mq_q[0] <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
			neg_q[0] <= num[NUM_W-1];
			side_q[0] <= side_in;
			for (int i = 0; i < NUM_W; i++) begin
				rem_q[i+1] <= rem_n[i];
				mq_q[i+1] <= mq_n[i];
				neg_q[i+1] <= neg_q[i];
				side_q[i+1] <= side_q[i];
			end
			cq_q[0] <= qfin;
			cs_q[0] <= side_q[NUM_W];
			for (int p = 1; p <= PAD; p++) begin
				cq_q[p] <= cq_q[p-1];
				cs_q[p] <= cs_q[p-1];
			end
		end
	end

	assign quo = cq_q[PAD];
	assign side_out = cs_q[PAD];

endmodule

// File: hdl/tpw_back.sv
module tpw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tpw_pkg::cfg_t  cfg,
	input  tpw_pkg::item_t head,
	input  logic           head_empty,
	output logic           head_pop,
	input  logic           adv,
	output logic           res_push,
	output tpw_pkg::res_t  res
);

	localparam int VW = tpw_pkg::VEC_W;
	localparam int A_W = 66;
	localparam int P3_W = 95;
	localparam int P5_W = 96;
	localparam int B_W = 98;
	localparam int LL_W = 2 * tpw_pkg::LEN_W;
	localparam int XL_W = 63;
	localparam int D_W = 3 * tpw_pkg::LEN_W;
	localparam int DIV_LAT = B_W + 2;
	localparam int NSTG = 4 + DIV_LAT + 3;
	localparam int NT = 6;
	localparam int T_ZZ = 0;
	localparam int T_YY = 1;
	localparam int T_YZ = 2;
	localparam int T_XX = 3;
	localparam int T_XY = 4;
	localparam int T_XZ = 5;

	function automatic logic [63:0] mul_lo(input logic signed [32:0] c, input logic [31:0] n);
		logic signed [65:0] p;
		p = c * $signed({1'b0, n});
		return p[63:0];
	endfunction

	function automatic logic [31:0] mul_hi(input logic signed [32:0] c, input logic [31:0] n);
		logic [63:0] p;
		p = c[31:0] * n;
		return p[31:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [63:0] w);
		if (!w[63] && (|w[62:31])) begin
			return 32'h7fff_ffff;
		end else if (w[63] && !(&w[62:31])) begin
			return 32'h8000_0000;
		end
		return w[31:0];
	endfunction

	// Products of the cell matrix that only change with the configuration.
	logic [LL_W-1:0] lylz_q;
	logic signed [XL_W-1:0] xzly_q;
	logic [LL_W-1:0] dp0_q, dp1_q;
	logic [D_W-1:0] d_q;
	logic signed [63:0] xzly_full;

	assign xzly_full = cfg.xz * $signed({1'b0, cfg.ly});

	always_ff @(posedge clk) begin
		lylz_q <= cfg.ly * cfg.lz;
		xzly_q <= xzly_full[XL_W-1:0];
		dp0_q <= cfg.lx * lylz_q[tpw_pkg::LEN_W-1:0];
		dp1_q <= cfg.lx * lylz_q[LL_W-1:tpw_pkg::LEN_W];
		d_q <= D_W'(dp0_q) + (D_W'(dp1_q) << tpw_pkg::LEN_W);
	end

	logic [NSTG-1:0] vld_q;

	assign head_pop = adv && !head_empty;
	assign res_push = adv && vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], !head_empty};
		end
	end

	tpw_pkg::item_t it_s1, it_s2, it_s3, it_s4;
	logic signed [64:0] p1_s1, p2_s1, p3a_s1, p3b_s1;
	logic signed [65:0] p5a_s1;
	logic signed [63:0] p5b_s1;
	logic signed [A_W-1:0] a_s2, a_s3, a_s4;
	logic signed [P3_W-1:0] p3_s2;
	logic signed [P5_W-1:0] p5_s2;
	logic signed [64:0] q0_s3, q1_s3;
	logic signed [33:0] q2_s3;
	logic signed [B_W-1:0] pbx_s3, b_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1 <= head;
			p1_s1 <= head.ry * $signed({1'b0, cfg.lz});
			p2_s1 <= cfg.yz * head.rz;
			p3a_s1 <= head.rx * $signed({1'b0, lylz_q[tpw_pkg::LEN_W-1:0]});
			p3b_s1 <= head.rx * $signed({1'b0, lylz_q[LL_W-1:tpw_pkg::LEN_W]});
			p5a_s1 <= head.rz * $signed({1'b0, xzly_q[31:0]});
			p5b_s1 <= head.rz * $signed(xzly_q[XL_W-1:32]);

			it_s2 <= it_s1;
			a_s2 <= A_W'(p1_s1) - A_W'(p2_s1);
			p3_s2 <= P3_W'(p3a_s1) + (P3_W'(p3b_s1) <<< tpw_pkg::LEN_W);
			p5_s2 <= P5_W'(p5a_s1) + (P5_W'(p5b_s1) <<< 32);

			it_s3 <= it_s2;
			a_s3 <= a_s2;
			q0_s3 <= cfg.xy * $signed({1'b0, a_s2[31:0]});
			q1_s3 <= cfg.xy * $signed({1'b0, a_s2[63:32]});
			q2_s3 <= cfg.xy * $signed(a_s2[A_W-1:64]);
			pbx_s3 <= B_W'(p3_s2) - B_W'(p5_s2);

			it_s4 <= it_s3;
			a_s4 <= a_s3;
			b_s4 <= pbx_s3 - B_W'(q0_s3) - (B_W'(q1_s3) <<< 32) - (B_W'(q2_s3) <<< 64);
		end
	end

	// Three floor divisions run side by side and finish in the same cycle.
	logic signed [B_W:0] nx_q;
	logic signed [A_W:0] ny_q;
	logic signed [VW:0] nz_q;
	logic [VW:0] sx_out;
	logic [VW-1:0] sy_out, sz_out;

	tpw_floordiv #(
		.NUM_W(B_W), .DEN_W(D_W), .PAD(0), .SIDE_W(VW + 1)
	) u_div_x (
		.clk(clk), .en(adv), .num(b_s4), .den(d_q),
		.side_in({it_s4.err, it_s4.rx}), .quo(nx_q), .side_out(sx_out)
	);

	tpw_floordiv #(
		.NUM_W(A_W), .DEN_W(LL_W), .PAD(B_W - A_W), .SIDE_W(VW)
	) u_div_y (
		.clk(clk), .en(adv), .num(a_s4), .den(lylz_q),
		.side_in(it_s4.ry), .quo(ny_q), .side_out(sy_out)
	);

	tpw_floordiv #(
		.NUM_W(VW), .DEN_W(tpw_pkg::LEN_W), .PAD(B_W - VW), .SIDE_W(VW)
	) u_div_z (
		.clk(clk), .en(adv), .num(it_s4.rz), .den(cfg.lz),
		.side_in(it_s4.rz), .quo(nz_q), .side_out(sz_out)
	);

	// The lattice vector is subtracted modulo 2^64; the true result is small.
	logic [63:0] nx64, ny64, nz64;
	logic signed [32:0] cf [NT];
	logic [63:0] nv [NT];

	assign nx64 = nx_q[63:0];
	assign ny64 = ny_q[63:0];
	assign nz64 = {{(64 - VW - 1){nz_q[VW]}}, nz_q};

	always_comb begin
		cf[T_ZZ] = $signed({2'b00, cfg.lz});
		cf[T_YY] = $signed({2'b00, cfg.ly});
		cf[T_YZ] = 33'(cfg.yz);
		cf[T_XX] = $signed({2'b00, cfg.lx});
		cf[T_XY] = 33'(cfg.xy);
		cf[T_XZ] = 33'(cfg.xz);
		nv[T_ZZ] = nz64;
		nv[T_YY] = ny64;
		nv[T_YZ] = nz64;
		nv[T_XX] = nx64;
		nv[T_XY] = ny64;
		nv[T_XZ] = nz64;
	end

	logic [63:0] lo_s5 [NT];
	logic [31:0] hi_s5 [NT];
	logic [63:0] t_s6 [NT];
	logic [63:0] rx_s5, ry_s5, rz_s5, rx_s6, ry_s6, rz_s6;
	logic err_s5, err_s6, err_s7;
	logic [63:0] wx_s7, wy_s7, wz_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NT; k++) begin
				lo_s5[k] <= mul_lo(cf[k], nv[k][31:0]);
				hi_s5[k] <= mul_hi(cf[k], nv[k][63:32]);
				t_s6[k] <= lo_s5[k] + {hi_s5[k], 32'h0};
			end
			rx_s5 <= 64'($signed(sx_out[VW-1:0]));
			ry_s5 <= 64'($signed(sy_out));
			rz_s5 <= 64'($signed(sz_out));
			err_s5 <= sx_out[VW];
			rx_s6 <= rx_s5;
			ry_s6 <= ry_s5;
			rz_s6 <= rz_s5;
			err_s6 <= err_s5;
			wz_s7 <= rz_s6 - t_s6[T_ZZ];
			wy_s7 <= ry_s6 - t_s6[T_YY] - t_s6[T_YZ];
			wx_s7 <= rx_s6 - t_s6[T_XX] - t_s6[T_XY] - t_s6[T_XZ];
			err_s7 <= err_s6;
		end
	end

	always_comb begin
		if (err_s7) begin
			res.wx = '0;
			res.wy = '0;
			res.wz = '0;
			res.status = tpw_pkg::STATUS_NON_PERIODIC;
		end else begin
			res.wx = sat32(wx_s7);
			res.wy = sat32(wy_s7);
			res.wz = sat32(wz_s7);
			res.status = tpw_pkg::STATUS_OK;
		end
	end

endmodule

// File: hdl/triclinic_periodic_wrap_unit.sv
// Triclinic periodic wrap unit. Each input word carries a point (command 0) or two points whose
// difference is wrapped (command 1), all in signed fixed point with FRAC_BITS fractional bits,
// and each produces exactly one result word with the vector reduced into the cell spanned by the
// upper-triangular box matrix held in the configuration registers. The result is
// r - H * floor(inv(H) * r), with every floor taken exactly; x and y saturate to the 32-bit
// range when large tilts push them out. If any axis is marked non-periodic or a cell length is
// zero, the result is a zero vector with status 1. The unit accepts one word per clock while
// full is low. An accepted word passes through the input queue, four multiply stages, the
// pipelined divider for the x fraction (an input register, 98 stages that each resolve one
// quotient bit, and an output register), three stages that subtract the lattice vector, and
// the write into the result queue. A small input queue decouples the classifying front end from
// the arithmetic pipeline, and a two-entry result queue lets the consumer stall: when it fills,
// the whole pipeline holds and the input queue backs up until full is raised. Configuration
// writes are always accepted (cfg_ready is tied high) and must only be issued while no word is
// in flight; derived matrix products settle through their registers (ly*lz, then the lx partial
// products, then the cell volume) after a write.
`include "assert_macros.svh"

module triclinic_periodic_wrap_unit #(
	parameter int FRAC_BITS = 16,
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input side.
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  command,
	input  logic signed [tpw_pkg::COORD_W-1:0]    first_x,
	input  logic signed [tpw_pkg::COORD_W-1:0]    first_y,
	input  logic signed [tpw_pkg::COORD_W-1:0]    first_z,
	input  logic signed [tpw_pkg::COORD_W-1:0]    second_x,
	input  logic signed [tpw_pkg::COORD_W-1:0]    second_y,
	input  logic signed [tpw_pkg::COORD_W-1:0]    second_z,
	// Result side.
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [tpw_pkg::COORD_W-1:0]    wrapped_x,
	output logic signed [tpw_pkg::COORD_W-1:0]    wrapped_y,
	output logic signed [tpw_pkg::COORD_W-1:0]    wrapped_z,
	output logic                                  status,
	// Configuration write channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tpw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tpw_pkg::CFG_DATA_W-1:0]        cfg_data
);

	// One unit length in the fixed-point format is the reset cell length.
	localparam logic [tpw_pkg::LEN_W-1:0] UNIT_LEN = tpw_pkg::LEN_W'(2 ** FRAC_BITS);
	localparam int RW = $bits(tpw_pkg::res_t);

	tpw_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lx <= UNIT_LEN;
			cfg_q.ly <= UNIT_LEN;
			cfg_q.lz <= UNIT_LEN;
			cfg_q.xy <= '0;
			cfg_q.xz <= '0;
			cfg_q.yz <= '0;
			cfg_q.mask <= tpw_pkg::MASK_ALL_PERIODIC;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tpw_pkg::CFG_CELL_LEN_X: cfg_q.lx <= cfg_data[tpw_pkg::LEN_W-1:0];
				tpw_pkg::CFG_TILT_XY: cfg_q.xy <= $signed(cfg_data);
				tpw_pkg::CFG_TILT_XZ: cfg_q.xz <= $signed(cfg_data);
				tpw_pkg::CFG_CELL_LEN_Y: cfg_q.ly <= cfg_data[tpw_pkg::LEN_W-1:0];
				tpw_pkg::CFG_TILT_YZ: cfg_q.yz <= $signed(cfg_data);
				tpw_pkg::CFG_CELL_LEN_Z: cfg_q.lz <= cfg_data[tpw_pkg::LEN_W-1:0];
				tpw_pkg::CFG_PERIODIC_MASK: cfg_q.mask <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// The front end forms the vector, flags unusable cells and queues the word.
	tpw_pkg::item_t head;
	logic head_empty, head_pop;

	tpw_front #(
		.DEPTH(MID_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.command(command),
		.first_x(first_x),
		.first_y(first_y),
		.first_z(first_z),
		.second_x(second_x),
		.second_y(second_y),
		.second_z(second_z),
		.cfg(cfg_q),
		.head(head),
		.head_empty(head_empty),
		.head_pop(head_pop)
	);

	// The arithmetic pipeline moves only while the result queue has room.
	logic out_full, res_push, adv;
	tpw_pkg::res_t res, out_res;
	logic [RW-1:0] out_word;

	assign adv = !out_full;

	tpw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.head_empty(head_empty),
		.head_pop(head_pop),
		.adv(adv),
		.res_push(res_push),
		.res(res)
	);

	tpw_fifo #(
		.W(RW),
		.DEPTH(OUT_DEPTH)
	) u_out_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(res_push),
		.wr_data(res),
		.full(out_full),
		.rd_en(pop),
		.rd_data(out_word),
		.empty(empty)
	);

	assign out_res = tpw_pkg::res_t'(out_word);
	assign wrapped_x = out_res.wx;
	assign wrapped_y = out_res.wy;
	assign wrapped_z = out_res.wz;
	assign status = out_res.status;

	// An error result never carries a nonzero vector.
	`TPW_ASSERT(a_err_zero, (!empty && status) |-> !(|{wrapped_x, wrapped_y, wrapped_z}), "error with vector")
	// The pipeline must never hand a word to a full result queue.
	`TPW_ASSERT(a_push_room, res_push |-> !out_full, "result pushed into full queue")
	// Taking a result without a new one arriving always frees a slot.
	`TPW_ASSERT_NEXT(a_pop_frees, pop && !empty && !res_push, !out_full, "full after pop")

endmodule
